// ===== hdl/qtcb_pkg.sv =====
`default_nettype none
package qtcb_pkg;

  // cfg register indexes
  localparam logic REG_SPAN_LIMIT = 1'b0;
  localparam logic REG_MIN_COUNT  = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ZFILL,
    ST_ROUND,
    ST_SEED,
    ST_SEEDRD,
    ST_SCAN,
    ST_CHKRD,
    ST_CHK,
    ST_COMMIT,
    ST_NEXTSEED,
    ST_ASSIGN,
    ST_LABEL,
    ST_EMIT,
    ST_DONE
  } state_t;

  // Compare unit request / response
  typedef struct packed {
    logic        init;   // load box from coordinate
    logic        check;  // evaluate coordinate against box
    logic        commit; // apply widened bounds
  } box_ctl_t;

  typedef struct packed {
    logic        enclosed;
    logic        fits;
  } box_sts_t;

endpackage
`default_nettype wire

// ===== hdl/qtcb_box_unit.sv =====
`default_nettype none
// Box bounds and one shared compare/span unit, one dimension per cycle.
module qtcb_box_unit #(
  parameter int DIM = 4
) (
  input  wire                    clk,
  input  wire [$clog2(DIM+1)-1:0] dim_sel,
  input  wire signed [15:0]      coord,
  input  wire [15:0]             span_limit,
  input  wire qtcb_pkg::box_ctl_t ctl,
  input  wire                    clr_acc,
  output qtcb_pkg::box_sts_t     sts
);
  import qtcb_pkg::*;

  localparam int DW = (DIM > 1) ? $clog2(DIM) : 1;

  logic signed [15:0] lo_r [DIM];
  logic signed [15:0] hi_r [DIM];
  logic signed [15:0] nlo_r [DIM];
  logic signed [15:0] nhi_r [DIM];
  logic enclosed_r, fits_r;
  logic signed [15:0] cur_lo, cur_hi, new_lo, new_hi;
  logic [16:0] span;
  logic [DW-1:0] di;

  assign di     = dim_sel[DW-1:0];
  assign cur_lo = lo_r[di];
  assign cur_hi = hi_r[di];
  assign new_lo = (coord < cur_lo) ? coord : cur_lo;
  assign new_hi = (coord > cur_hi) ? coord : cur_hi;
  assign span   = 17'({new_hi[15], new_hi} - {new_lo[15], new_lo});

  always_ff @(posedge clk) begin
    if (clr_acc) begin
      enclosed_r <= 1'b1;
      fits_r     <= 1'b1;
    end else if (ctl.check) begin
      if (coord < cur_lo || coord > cur_hi) enclosed_r <= 1'b0;
      if (span > {1'b0, span_limit}) fits_r <= 1'b0;
      nlo_r[di] <= new_lo;
      nhi_r[di] <= new_hi;
    end
    if (ctl.init) begin
      lo_r[di] <= coord;
      hi_r[di] <= coord;
    end
    if (ctl.commit) begin
      for (int d = 0; d < DIM; d++) begin
        lo_r[d] <= nlo_r[d];
        hi_r[d] <= nhi_r[d];
      end
    end
  end

  assign sts.enclosed = enclosed_r;
  assign sts.fits     = fits_r;
endmodule
`default_nettype wire

// ===== hdl/qt_cluster_box_diameter.sv =====
`default_nettype none
// Quality-threshold clustering on an axis-aligned box diameter.
// Input: each start pulse (when busy is low) loads one coordinate, one item
// per cycle; DIM coordinates form a point, up to MAX_POINTS points (further
// coordinates are dropped). in_end_of_set marks the last coordinate; missing
// coordinates of that point are filled with zero and clustering begins.
// Clustering: every round tries each unassigned point as seed and scans all
// other unassigned points, one coordinate per cycle through a single shared
// compare/span unit (box_unit), with a registered point memory read, then
// writes the labels of the winning cluster by walking all points. There are
// at most N rounds.
// Output: one item per point, point_number in load order, one per cycle,
// marked by out_valid, the first in the cycle after emission starts; out_last
// on the final point. busy stays high from end_of_set through the cycle
// that carries the last label. The receiver cannot stall; items are
// presented exactly once.
// Config: cfg_we/cfg_index/cfg_data, index 0 span limit, 1 min_count; the user
// must write them only while idle, the block itself does not enforce it.
// Reset (synchronous, rst_n low): returns to loading with an empty set,
// span limit 256, min_count 1. No memory clearing pass.
module qt_cluster_box_diameter #(
  parameter int MAX_POINTS = 64,
  parameter int DIM        = 4
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire signed [15:0] in_coordinate,
  input  wire               in_end_of_set,
  output logic              out_valid,
  output logic [5:0]        out_point_number,
  output logic [5:0]        out_cluster_label,
  output logic              out_unassigned,
  output logic              out_last,
  input  wire               cfg_we,
  input  wire               cfg_index,
  input  wire [15:0]        cfg_data
);
  import qtcb_pkg::*;

  localparam int PW  = $clog2(MAX_POINTS + 1);   // count width
  localparam int PI  = $clog2(MAX_POINTS);       // index width
  localparam int DCW = $clog2(DIM + 1);
  localparam int DW  = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AW  = PI + DW;
  localparam int DEPTH = 1 << AW;

  state_t state_r, state_nxt;

  logic [15:0] span_limit_r;
  logic [6:0]  min_count_r;

  logic [PW-1:0]  point_count_r, point_count_nxt;
  logic [DCW-1:0] coord_cnt_r, coord_cnt_nxt;
  logic [PI-1:0]  seed_r, seed_nxt, scan_r, scan_nxt;
  logic [DCW-1:0] dim_r, dim_nxt;
  logic [MAX_POINTS-1:0] assigned_r, assigned_nxt;
  logic [MAX_POINTS-1:0] cand_r, cand_nxt, best_r, best_nxt;
  logic [PW-1:0]  cand_cnt_r, cand_cnt_nxt, best_cnt_r, best_cnt_nxt;
  logic [5:0]     next_cluster_r, next_cluster_nxt;
  logic           label_we;

  // label memory, one entry per point
  logic [5:0]     label_mem [MAX_POINTS];
  logic [5:0]     label_rd_r;

  // result registers
  logic           out_valid_r, out_valid_nxt;
  logic [5:0]     out_pnum_r;
  logic           out_unas_r;
  logic           out_last_r;

  // point memory
  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rd_r;
  logic               wr_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic signed [15:0] wr_data;
  logic [PI-1:0]      rd_pt;

  box_ctl_t       box_ctl;
  box_sts_t       box_sts;
  logic           clr_acc;
  logic [DCW-1:0] box_dim;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  assign rd_addr = {rd_pt, dim_r[DW-1:0]};
  // the read is registered, so its data belongs to dim_r-1
  assign box_dim = (dim_r != '0) ? dim_r - DCW'(1) : '0;

  qtcb_box_unit #(.DIM(DIM)) u_box (
    .clk         (clk),
    .dim_sel     (box_dim),
    .coord       (rd_r),
    .span_limit  (span_limit_r),
    .ctl         (box_ctl),
    .clr_acc     (clr_acc),
    .sts         (box_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_limit_r <= 16'd256;
      min_count_r  <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPAN_LIMIT: span_limit_r <= cfg_data;
        REG_MIN_COUNT:  min_count_r  <= cfg_data[6:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_LOAD;
      point_count_r  <= '0;
      coord_cnt_r    <= '0;
      seed_r         <= '0;
      scan_r         <= '0;
      dim_r          <= '0;
      assigned_r     <= '0;
      cand_r         <= '0;
      best_r         <= '0;
      cand_cnt_r     <= '0;
      best_cnt_r     <= '0;
      next_cluster_r <= '0;
    end else begin
      state_r        <= state_nxt;
      point_count_r  <= point_count_nxt;
      coord_cnt_r    <= coord_cnt_nxt;
      seed_r         <= seed_nxt;
      scan_r         <= scan_nxt;
      dim_r          <= dim_nxt;
      assigned_r     <= assigned_nxt;
      cand_r         <= cand_nxt;
      best_r         <= best_nxt;
      cand_cnt_r     <= cand_cnt_nxt;
      best_cnt_r     <= best_cnt_nxt;
      next_cluster_r <= next_cluster_nxt;
    end
  end

  // labels written one point per cycle, read registered at scan_r
  always_ff @(posedge clk) begin
    if (label_we) label_mem[scan_r] <= next_cluster_r;
    label_rd_r <= label_mem[scan_r];
  end

  logic last_pt;
  logic scan_skip;
  logic [PI-1:0] last_idx;
  assign last_idx  = PI'(point_count_r - PW'(1));
  assign last_pt   = (scan_r == last_idx);
  assign scan_skip = (scan_r == seed_r) || assigned_r[scan_r];

  // result item registered from the emit cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_pnum_r  <= '0;
      out_unas_r  <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      out_pnum_r  <= 6'(scan_r);
      out_unas_r  <= !assigned_r[scan_r];
      out_last_r  <= last_pt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    point_count_nxt  = point_count_r;
    coord_cnt_nxt    = coord_cnt_r;
    seed_nxt         = seed_r;
    scan_nxt         = scan_r;
    dim_nxt          = dim_r;
    assigned_nxt     = assigned_r;
    cand_nxt         = cand_r;
    best_nxt         = best_r;
    cand_cnt_nxt     = cand_cnt_r;
    best_cnt_nxt     = best_cnt_r;
    next_cluster_nxt = next_cluster_r;
    wr_en    = 1'b0;
    wr_addr  = {PI'(point_count_r), coord_cnt_r[DW-1:0]};
    wr_data  = in_coordinate;
    rd_pt    = seed_r;
    box_ctl  = '0;
    clr_acc  = 1'b0;
    label_we = 1'b0;
    busy     = 1'b1;
    out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          if (point_count_r < PW'(MAX_POINTS)) begin
            wr_en = 1'b1;
            if (coord_cnt_r == DCW'(DIM - 1)) begin
              coord_cnt_nxt   = '0;
              point_count_nxt = point_count_r + PW'(1);
            end else begin
              coord_cnt_nxt = coord_cnt_r + DCW'(1);
              if (in_end_of_set) state_nxt = ST_ZFILL;
            end
          end
          if (in_end_of_set && state_nxt != ST_ZFILL) state_nxt = ST_ROUND;
        end
      end
      ST_ZFILL: begin
        wr_en   = 1'b1;
        wr_data = '0;
        if (coord_cnt_r == DCW'(DIM - 1)) begin
          coord_cnt_nxt   = '0;
          point_count_nxt = point_count_r + PW'(1);
          state_nxt       = ST_ROUND;
        end else begin
          coord_cnt_nxt = coord_cnt_r + DCW'(1);
        end
      end
      ST_ROUND: begin
        best_nxt     = '0;
        best_cnt_nxt = '0;
        seed_nxt     = '0;
        if (point_count_r == '0 || (&assigned_r[MAX_POINTS-1:0]) ||
            assigned_r == ({MAX_POINTS{1'b1}} >> (MAX_POINTS - point_count_r))) begin
          scan_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        if (assigned_r[seed_r]) begin
          state_nxt = ST_NEXTSEED;
        end else begin
          dim_nxt   = '0;
          state_nxt = ST_SEEDRD;
        end
      end
      ST_SEEDRD: begin
        // address of dim_r goes out; data of dim_r-1 loads the box
        rd_pt = seed_r;
        if (dim_r != '0) box_ctl.init = 1'b1;
        if (dim_r == DCW'(DIM)) begin
          dim_nxt      = '0;
          cand_nxt     = '0;
          cand_nxt[seed_r] = 1'b1;
          cand_cnt_nxt = PW'(1);
          scan_nxt     = '0;
          state_nxt    = ST_SCAN;
        end else begin
          dim_nxt = dim_r + DCW'(1);
        end
      end
      ST_SCAN: begin
        if (scan_skip) begin
          if (last_pt) state_nxt = ST_NEXTSEED;
          else scan_nxt = scan_r + PI'(1);
        end else begin
          dim_nxt   = '0;
          clr_acc   = 1'b1;
          state_nxt = ST_CHKRD;
        end
      end
      ST_CHKRD: begin
        rd_pt = scan_r;
        if (dim_r != '0) box_ctl.check = 1'b1;
        if (dim_r == DCW'(DIM)) state_nxt = ST_CHK;
        else dim_nxt = dim_r + DCW'(1);
      end
      ST_CHK: begin
        rd_pt = scan_r;
        if (box_sts.enclosed || box_sts.fits) begin
          cand_nxt[scan_r] = 1'b1;
          cand_cnt_nxt     = cand_cnt_r + PW'(1);
          if (!box_sts.enclosed) box_ctl.commit = 1'b1;
        end
        if (last_pt) begin
          state_nxt = ST_COMMIT;
        end else begin
          scan_nxt  = scan_r + PI'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_COMMIT: begin
        state_nxt = ST_NEXTSEED;
      end
      ST_NEXTSEED: begin
        if (!assigned_r[seed_r] && cand_cnt_r > best_cnt_r) begin
          best_cnt_nxt = cand_cnt_r;
          best_nxt     = cand_r;
        end
        cand_cnt_nxt = '0;
        if (seed_r == last_idx) begin
          state_nxt = ST_ASSIGN;
        end else begin
          seed_nxt  = seed_r + PI'(1);
          state_nxt = ST_SEED;
        end
      end
      ST_ASSIGN: begin
        scan_nxt = '0;
        if (best_cnt_r == '0 || 7'(best_cnt_r) < min_count_r) begin
          state_nxt = ST_EMIT;
        end else begin
          assigned_nxt = assigned_r | best_r;
          state_nxt    = ST_LABEL;
        end
      end
      ST_LABEL: begin
        // walk the points, label the members of the winning candidate
        label_we = best_r[scan_r];
        if (last_pt) begin
          next_cluster_nxt = next_cluster_r + 6'd1;
          state_nxt        = ST_ROUND;
        end else begin
          scan_nxt = scan_r + PI'(1);
        end
      end
      ST_EMIT: begin
        if (point_count_r != '0) out_valid_nxt = 1'b1;
        if (point_count_r == '0 || last_pt) begin
          point_count_nxt  = '0;
          coord_cnt_nxt    = '0;
          assigned_nxt     = '0;
          next_cluster_nxt = '0;
          state_nxt        = ST_DONE;
        end else begin
          scan_nxt = scan_r + PI'(1);
        end
      end
      ST_DONE: begin
        // last label is on the outputs this cycle
        state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_point_number  = out_pnum_r;
  assign out_unassigned    = out_unas_r;
  assign out_cluster_label = out_unas_r ? 6'd0 : label_rd_r;
  assign out_last          = out_last_r;

`ifndef SYNTHESIS
  a_no_emit_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !out_valid) else $error("result while idle");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !busy) else $error("busy after last");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    point_count_r <= PW'(MAX_POINTS)) else $error("count overflow");
`endif
endmodule
`default_nettype wire
